@@ hdl/mssb_pkg.sv @@
package mssb_pkg;

  localparam int DEF_NUM_STACKS = 8;
  localparam int DEF_NUM_SLOTS  = 64;

  localparam int DATA_W    = 32;
  localparam int STK_IDX_W = 3;
  localparam int STATUS_W  = 2;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'b01,
    FSM_FIN  = 2'b10
  } fsm_t;

endpackage

@@ hdl/mssb_ram.sv @@
module mssb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/multi_stack_shared_buffer_top.sv @@
// Several LIFO stacks that share one slot store. A push (op 0) takes the
// head of the free list, stores the value there and makes that slot the
// new top of the chosen stack; it returns status 1 when no slot is free or
// the stack index is beyond NUM_STACKS. A pop (op 1) unlinks the top slot,
// hands it back to the free list and returns its value; it returns status 2
// with a zero value on an empty or nonexistent stack. Every accepted beat
// yields exactly one result beat. Each item has an accept and a commit
// cycle: in the accept cycle the slot pointer (free head or stack top)
// addresses the link and data memories, and in the commit cycle the
// registered read data is used and the link, data, top and free head are
// written back. A new item is taken only once the current one has
// committed. The result register lets a new item enter while the previous
// result still waits; the commit cycle holds until that register is free.
// Slot links come up as "slot i links i+1" through a fill mark: slots at or
// above it were never allocated, so no clearing pass is needed and the
// block takes items from the first cycle after reset.
module multi_stack_shared_buffer_top #(
  parameter int NUM_STACKS = mssb_pkg::DEF_NUM_STACKS,
  parameter int NUM_SLOTS  = mssb_pkg::DEF_NUM_SLOTS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_op,
  input  logic [mssb_pkg::STK_IDX_W-1:0]      in_stack_index,
  input  logic signed [mssb_pkg::DATA_W-1:0]  in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mssb_pkg::STATUS_W-1:0]       out_status,
  output logic signed [mssb_pkg::DATA_W-1:0]  out_popped_value
);

  import mssb_pkg::*;

  // Only stacks reachable through the 3-bit index get storage.
  localparam int STK_MAX  = 1 << STK_IDX_W;
  localparam int STK_USED = (NUM_STACKS < STK_MAX) ? NUM_STACKS : STK_MAX;
  localparam int SW       = (STK_USED > 1) ? $clog2(STK_USED) : 1;
  localparam int AW       = $clog2(NUM_SLOTS);
  localparam int PW       = $clog2(NUM_SLOTS + 1);
  localparam logic [PW-1:0] PTR_NULL = PW'(NUM_SLOTS);

  fsm_t                  state_r, state_nxt;
  logic [PW-1:0]         top_r [STK_USED];
  logic [PW-1:0]         free_head_r, free_head_nxt;
  logic [PW-1:0]         fill_r, fill_nxt;

  // Item held between accept and commit.
  logic                  op_r;
  logic [STK_IDX_W-1:0]  sidx_r;
  logic [DATA_W-1:0]     value_r;
  logic [PW-1:0]         slot_r;

  logic                  out_valid_r;
  status_t               out_status_r;
  logic [DATA_W-1:0]     out_popped_value_r;

  logic                  in_acc;
  logic                  out_free;
  logic                  commit;
  logic                  in_stk_ok;
  logic [PW-1:0]         in_top;
  logic [PW-1:0]         rd_slot;

  logic                  stk_ok;
  logic [PW-1:0]         cur_top;
  logic                  fresh;
  logic [PW-1:0]         link_seen;
  logic                  do_push;
  logic                  do_pop;
  status_t               status_c;

  logic [PW-1:0]         link_rdata;
  logic [DATA_W-1:0]     data_rdata;
  logic                  link_we;
  logic [PW-1:0]         link_wdata;
  logic                  data_we;
  logic [PW-1:0]         top_wdata;

  assign in_stall = (state_r != FSM_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // Pick the slot to read in the accept cycle: free head for a push,
  // stack top for a pop.
  always_comb begin
    in_stk_ok = (int'(in_stack_index) < STK_USED);
    in_top    = in_stk_ok ? top_r[in_stack_index[SW-1:0]] : PTR_NULL;
    rd_slot   = (in_op == OP_POP) ? in_top : free_head_r;
  end

  mssb_ram #(
    .WIDTH(PW),
    .DEPTH(NUM_SLOTS)
  ) u_link_ram (
    .clk  (clk),
    .we   (link_we),
    .waddr(slot_r[AW-1:0]),
    .wdata(link_wdata),
    .re   (in_acc),
    .raddr(rd_slot[AW-1:0]),
    .rdata(link_rdata)
  );

  mssb_ram #(
    .WIDTH(DATA_W),
    .DEPTH(NUM_SLOTS)
  ) u_data_ram (
    .clk  (clk),
    .we   (data_we),
    .waddr(slot_r[AW-1:0]),
    .wdata(value_r),
    .re   (in_acc),
    .raddr(rd_slot[AW-1:0]),
    .rdata(data_rdata)
  );

  // Commit cycle: decide, then write back links, data and pointers.
  always_comb begin
    stk_ok    = (int'(sidx_r) < STK_USED);
    cur_top   = stk_ok ? top_r[sidx_r[SW-1:0]] : PTR_NULL;
    // A never-allocated slot is taken to link to slot + 1, its reset link.
    fresh     = (slot_r >= fill_r);
    link_seen = fresh ? (slot_r + PW'(1)) : link_rdata;
    commit    = (state_r == FSM_FIN) && out_free;

    do_push   = 1'b0;
    do_pop    = 1'b0;
    status_c  = ST_DONE;
    if (op_r == OP_PUSH) begin
      if (!stk_ok || (free_head_r == PTR_NULL)) begin
        status_c = ST_FULL;
      end else begin
        do_push = 1'b1;
      end
    end else begin
      if (!stk_ok || (cur_top == PTR_NULL)) begin
        status_c = ST_EMPTY;
      end else begin
        do_pop = 1'b1;
      end
    end

    link_we       = commit && (do_push || do_pop);
    data_we       = commit && do_push;
    link_wdata    = do_push ? cur_top : free_head_r;
    top_wdata     = do_push ? slot_r : link_seen;
    free_head_nxt = free_head_r;
    fill_nxt      = fill_r;
    if (commit && do_push) begin
      free_head_nxt = link_seen;
      if (fresh) begin
        fill_nxt = fill_r + PW'(1);
      end
    end else if (commit && do_pop) begin
      free_head_nxt = slot_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE: begin
        if (in_acc) begin
          state_nxt = FSM_FIN;
        end
      end
      FSM_FIN: begin
        if (out_free) begin
          state_nxt = FSM_IDLE;
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      free_head_r <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < STK_USED; i++) begin
        top_r[i] <= PTR_NULL;
      end
    end else begin
      state_r     <= state_nxt;
      free_head_r <= free_head_nxt;
      fill_r      <= fill_nxt;
      if (commit && (do_push || do_pop)) begin
        top_r[sidx_r[SW-1:0]] <= top_wdata;
      end
      // Advance the result register; hold it while the sink stalls.
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= in_op;
      sidx_r  <= in_stack_index;
      value_r <= in_value;
      slot_r  <= rd_slot;
    end
    if (commit) begin
      out_status_r       <= status_c;
      out_popped_value_r <= do_pop ? data_rdata : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_popped_value = out_popped_value_r;

endmodule
